/* design/bmsa_pkg.sv */
// shared types and constants of the batch mean and standard error accumulator
package bmsa_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FIELD_W    = 24;
  localparam int SUM_W      = 40;
  localparam int SQ_W       = 64;
  localparam int STEP_W     = 6;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // last step index of each serial phase
  localparam logic [STEP_W-1:0] ACC_LAST  = STEP_W'(FIELD_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SQ_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQ_W / 2 - 1);

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 136;

  // command codes
  localparam logic CMD_ACC    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_SINGLE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_T,
    S_ACC_C,
    S_DIV_M,
    S_DIV_Q,
    S_MUL,
    S_DIV_V,
    S_SQRT,
    S_DIV_P,
    S_FIN
  } state_t;

endpackage

/* design/batch_mean_stderr_accumulator_core.sv */
// top level of the batch mean and standard error accumulator
// An accumulate transaction (tuser 0) adds the two estimates, their squares
// and the particle count to running sums; the squares come from a shift-add
// multiplier that takes one bit per cycle, so an accumulate occupies the block
// for an accept and 2 x 24 multiply steps. Once the batch counter reaches 65535
// further accumulates are dropped. A report transaction (tuser 1) walks one
// shared bit-serial unit through all results: per estimator a 64-step divide
// for the mean, a 64-step divide for the mean of squares, a 40-step multiply
// for mean squared, a 64-step divide by n-1 and a 32-step square root, then a
// 64-step divide for the mean particle count. For a single batch only the
// mean divides run, and with no batches the report goes straight to the result.
// One transaction is worked on at a time; the result sits in an output
// register so the next input can be taken while it waits for out_tready.
module batch_mean_stderr_accumulator_core
  import bmsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // track_k [23:0], collision_est [47:24], particle_count [71:48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command [0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mean_track [23:0], stderr_track [47:24], mean_collision [71:48],
  // stderr_collision [95:72], mean_particles [119:96], batch_total [135:120]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [1:0]            out_tuser
);

  state_t state_r, state_nxt;

  // accumulator state
  logic [COUNT_BITS-1:0] count_r;
  logic [SUM_W-1:0]      tsum_r, csum_r, psum_r;
  logic [SQ_W-1:0]       tsq_r, csq_r;

  // serial datapath
  logic [STEP_W-1:0]     cnt_r;
  logic                  sel_r;        // 0 track, 1 collision
  logic [SQ_W-1:0]       x_r;          // dividend / quotient, sqrt remainder
  logic [COUNT_BITS:0]   r_r;          // divider partial remainder
  logic [SQ_W-1:0]       mc_r;         // multiplicand, sqrt bit
  logic [SUM_W-1:0]      mp_r;         // multiplier
  logic [SQ_W-1:0]       pr_r;         // product, sqrt root
  logic [SQ_W-1:0]       q_r;          // mean of squares
  logic [SUM_W-1:0]      m_r;          // mean of the estimator
  logic [FIELD_W-1:0]    ck_r;

  // staged results
  logic [FIELD_W-1:0]    mt_r, st_r, mcl_r, scl_r, mpt_r;

  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;
  logic                  out_valid_r;

  logic                  in_acc, last, out_free;
  logic [COUNT_BITS:0]   div_d, rem_sh, rem_new;
  logic                  ge;
  logic [SQ_W-1:0]       x_nxt, pr_step, v, trial, root_new;
  logic                  sq_ge;
  logic [FIELD_W-1:0]    tk, ck, pc;

  assign tk = in_tdata[23:0];
  assign ck = in_tdata[47:24];
  assign pc = in_tdata[71:48];

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // divider step: divisor is n, or n-1 for the variance
  assign div_d   = (state_r == S_DIV_V) ? {1'b0, count_r - COUNT_BITS'(1)} : {1'b0, count_r};
  assign rem_sh  = {r_r[COUNT_BITS-1:0], x_r[SQ_W-1]};
  assign ge      = rem_sh >= div_d;
  assign rem_new = ge ? rem_sh - div_d : rem_sh;
  assign x_nxt   = {x_r[SQ_W-2:0], ge};

  // shift-add multiplier step
  assign pr_step = mp_r[0] ? pr_r + mc_r : pr_r;
  assign v       = (q_r > pr_step) ? q_r - pr_step : '0;

  // square root step
  assign trial    = pr_r + mc_r;
  assign sq_ge    = x_r >= trial;
  assign root_new = sq_ge ? (pr_r >> 1) + mc_r : pr_r >> 1;

  // last step flag and handshake
  always_comb begin
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_ACC_T, S_ACC_C:         last = (cnt_r == ACC_LAST);
      S_MUL:                    last = (cnt_r == MUL_LAST);
      S_DIV_M, S_DIV_Q,
      S_DIV_V, S_DIV_P:         last = (cnt_r == DIV_LAST);
      S_SQRT:                   last = (cnt_r == SQRT_LAST);
      default:                  last = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == CMD_REPORT) begin
            state_nxt = (count_r == '0) ? S_FIN : S_DIV_M;
          end else if (count_r != COUNT_MAX) begin
            state_nxt = S_ACC_T;
          end
        end
      end
      S_ACC_T: if (last) state_nxt = S_ACC_C;
      S_ACC_C: if (last) state_nxt = S_IDLE;
      S_DIV_M: begin
        if (last) begin
          if (count_r != COUNT_BITS'(1)) state_nxt = S_DIV_Q;
          else                           state_nxt = sel_r ? S_DIV_P : S_DIV_M;
        end
      end
      S_DIV_Q: if (last) state_nxt = S_MUL;
      S_MUL:   if (last) state_nxt = S_DIV_V;
      S_DIV_V: if (last) state_nxt = S_SQRT;
      S_SQRT:  if (last) state_nxt = sel_r ? S_DIV_P : S_DIV_M;
      S_DIV_P: if (last) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      tsum_r      <= '0;
      csum_r      <= '0;
      psum_r      <= '0;
      tsq_r       <= '0;
      csq_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (last || state_r == S_IDLE || state_r == S_FIN) ? '0 : cnt_r + STEP_W'(1);
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
      if (in_acc && in_tuser == CMD_ACC && count_r != COUNT_MAX) begin
        count_r <= count_r + COUNT_BITS'(1);
        tsum_r  <= tsum_r + SUM_W'(tk);
        csum_r  <= csum_r + SUM_W'(ck);
        psum_r  <= psum_r + SUM_W'(pc);
      end
      if (state_r == S_ACC_T && last) tsq_r <= tsq_r + pr_step;
      if (state_r == S_ACC_C && last) csq_r <= csq_r + pr_step;
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        sel_r <= 1'b0;
        x_r   <= SQ_W'(tsum_r);
        r_r   <= '0;
        mc_r  <= SQ_W'(tk);
        mp_r  <= SUM_W'(tk);
        pr_r  <= '0;
        ck_r  <= ck;
      end
      S_ACC_T, S_ACC_C, S_MUL: begin
        pr_r <= pr_step;
        mc_r <= mc_r << 1;
        mp_r <= mp_r >> 1;
        if (state_r == S_ACC_T && last) begin
          mc_r <= SQ_W'(ck_r);
          mp_r <= SUM_W'(ck_r);
          pr_r <= '0;
        end
        if (state_r == S_MUL && last) begin
          x_r <= v;
          r_r <= '0;
        end
      end
      S_DIV_M, S_DIV_Q, S_DIV_V, S_DIV_P: begin
        x_r <= x_nxt;
        r_r <= rem_new;
        if (last) begin
          r_r <= '0;
          unique case (state_r)
            S_DIV_M: begin
              m_r <= x_nxt[SUM_W-1:0];
              if (sel_r) mcl_r <= x_nxt[FIELD_W-1:0];
              else       mt_r  <= x_nxt[FIELD_W-1:0];
              if (count_r != COUNT_BITS'(1)) begin
                x_r <= sel_r ? csq_r : tsq_r;
              end else if (sel_r) begin
                x_r <= SQ_W'(psum_r);
              end else begin
                sel_r <= 1'b1;
                x_r   <= SQ_W'(csum_r);
              end
            end
            S_DIV_Q: begin
              q_r  <= x_nxt;
              mc_r <= SQ_W'(m_r);
              mp_r <= m_r;
              pr_r <= '0;
            end
            S_DIV_V: begin
              pr_r <= '0;
              mc_r <= SQ_W'(1) << (SQ_W - 2);
            end
            default: mpt_r <= x_nxt[FIELD_W-1:0];
          endcase
        end
      end
      S_SQRT: begin
        if (sq_ge) x_r <= x_r - trial;
        pr_r <= root_new;
        mc_r <= mc_r >> 2;
        if (last) begin
          r_r <= '0;
          if (sel_r) begin
            scl_r <= root_new[FIELD_W-1:0];
            x_r   <= SQ_W'(psum_r);
          end else begin
            st_r  <= root_new[FIELD_W-1:0];
            sel_r <= 1'b1;
            x_r   <= SQ_W'(csum_r);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (count_r == '0) begin
            out_data_r <= '0;
            out_user_r <= ST_EMPTY;
          end else begin
            out_data_r <= {count_r, mpt_r,
                           (count_r == COUNT_BITS'(1)) ? '0 : scl_r, mcl_r,
                           (count_r == COUNT_BITS'(1)) ? '0 : st_r, mt_r};
            out_user_r <= (count_r == COUNT_BITS'(1)) ? ST_SINGLE : ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* design/bmsa_checker.sv */
// port-level checks of the accumulator core and their bind
module bmsa_checker
  import bmsa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata == '0)
    else $error("empty report carries data");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SINGLE |->
      out_tdata[135:120] == 16'd1 && out_tdata[47:24] == '0 && out_tdata[95:72] == '0)
    else $error("single batch report malformed");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK |-> out_tdata[135:120] > 16'd1)
    else $error("ok report with fewer than two batches");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tvalid && !out_tready |=> out_tvalid)
    else $error("result lost on input accept");

endmodule

bind batch_mean_stderr_accumulator_core bmsa_checker u_bmsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
